[rtl/csem_pkg.sv]
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants for the counting semaphore table
// Entry layout, command and status codes, and the word passed between the
// execute logic and the state it updates.
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int NUM_SEMS   = 64;
    localparam int IDX_W      = $clog2(NUM_SEMS);
    localparam int COUNT_BITS = 8;
    localparam int STATUS_W   = 3;
    localparam int KIND_W     = 2;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_OPEN  = 2'd0,
        KIND_UP    = 2'd1,
        KIND_DOWN  = 2'd2,
        KIND_CLOSE = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ALREADY  = 3'd1,
        ST_NOT_OPEN = 3'd2,
        ST_OVER     = 3'd3,
        ST_IN_USE   = 3'd4,
        ST_BLOCK    = 3'd5
    } status_t;

    typedef struct packed {
        cnt_t capacity;
        cnt_t count;
    } entry_t;

    typedef struct packed {
        logic   mem_wr;
        entry_t entry;
        logic   flag_wr;
        logic   flag_val;
    } upd_t;

    typedef struct packed {
        status_t status;
        cnt_t    count;
        logic    wake;
    } result_t;

endpackage

[rtl/csem_entry_ram.sv]
// ----------------------------------------------------------------------------
// csem_entry_ram: count and capacity store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module csem_entry_ram (
    input  logic              aclk,
    input  logic              wr_en,
    input  csem_pkg::idx_t    wr_addr,
    input  csem_pkg::entry_t  wr_data,
    input  logic              rd_en,
    input  csem_pkg::idx_t    rd_addr,
    output csem_pkg::entry_t  rd_data
);
    import csem_pkg::*;

    entry_t mem [NUM_SEMS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/csem_exec.sv]
// ----------------------------------------------------------------------------
// csem_exec: command execute logic
// Decides status, returned count, wake and the entry update for one word.
// ----------------------------------------------------------------------------
module csem_exec (
    input  csem_pkg::kind_t   kind,
    input  csem_pkg::cnt_t    initial_value,
    input  logic              is_open,
    input  csem_pkg::entry_t  entry,
    output csem_pkg::upd_t    upd,
    output csem_pkg::result_t res
);
    import csem_pkg::*;

    always_comb begin
        upd          = '0;
        upd.entry    = entry;
        res.status   = ST_OK;
        res.count    = '0;
        res.wake     = 1'b0;
        if (kind == KIND_OPEN) begin
            if (is_open) begin
                res.status = ST_ALREADY;
                res.count  = entry.count;
            end else begin
                upd.mem_wr         = 1'b1;
                upd.entry.count    = initial_value;
                upd.entry.capacity = initial_value;
                upd.flag_wr        = 1'b1;
                upd.flag_val       = 1'b1;
                res.count          = initial_value;
            end
        end else if (!is_open) begin
            res.status = ST_NOT_OPEN;
        end else begin
            case (kind)
                KIND_UP: begin
                    if (entry.count == '0) begin
                        upd.mem_wr      = 1'b1;
                        upd.entry.count = cnt_t'(1);
                        res.count       = cnt_t'(1);
                        res.wake        = 1'b1;
                    end else if (entry.count < entry.capacity) begin
                        upd.mem_wr      = 1'b1;
                        upd.entry.count = entry.count + cnt_t'(1);
                        res.count       = entry.count + cnt_t'(1);
                    end else begin
                        res.status = ST_OVER;
                        res.count  = entry.count;
                    end
                end
                KIND_DOWN: begin
                    if (entry.count == '0) begin
                        res.status = ST_BLOCK;
                    end else begin
                        upd.mem_wr      = 1'b1;
                        upd.entry.count = entry.count - cnt_t'(1);
                        res.count       = entry.count - cnt_t'(1);
                    end
                end
                KIND_CLOSE: begin
                    if (entry.count != entry.capacity) begin
                        res.status = ST_IN_USE;
                        res.count  = entry.count;
                    end else begin
                        upd.flag_wr  = 1'b1;
                        upd.flag_val = 1'b0;
                    end
                end
                default: begin
                    res.status = ST_NOT_OPEN;
                end
            endcase
        end
    end

endmodule

[rtl/counting_semaphore_table_unit.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit: table of counting semaphores
// Open, up, down and close commands on 64 entries, one result per command.
//
//   Channel | Direction | Ports
//   --------+-----------+------------------------------------------------
//   s_      | in        | s_valid, s_ready, s_kind, s_index, s_initial_value
//   m_      | out       | m_valid, m_ready, m_status, m_count, m_wake
//
// One word per cycle sustained while results are taken; a result word passes
// through the input register, which takes the word and starts the entry
// read, and then the result register, which takes the answer.
// The entry store has a registered read port; a write from the word ahead
// is forwarded to a following word on the same entry.
// Reset closes every entry at once and empties both registers.
// A stalled result holds the input register; new words wait only then.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [csem_pkg::KIND_W-1:0]    s_kind,
    input  logic [csem_pkg::IDX_W-1:0]     s_index,
    input  logic [csem_pkg::COUNT_BITS-1:0] s_initial_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [csem_pkg::STATUS_W-1:0]  m_status,
    output logic [csem_pkg::COUNT_BITS-1:0] m_count,
    output logic                           m_wake
);
    import csem_pkg::*;

    logic             s1_valid_reg;
    kind_t            s1_kind_reg;
    idx_t             s1_index_reg;
    cnt_t             s1_init_reg;
    logic             byp_hit_reg;
    entry_t           byp_data_reg;
    logic [NUM_SEMS-1:0] open_reg;
    logic             m_valid_reg;
    result_t          m_res_reg;

    logic    advance;
    logic    s_accept;
    logic    fire;
    logic    mem_wr;
    entry_t  rd_data;
    entry_t  cur_entry;
    upd_t    upd;
    result_t res;

    assign advance  = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign fire     = s1_valid_reg && advance;
    assign mem_wr   = fire && upd.mem_wr;

    csem_entry_ram u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (s1_index_reg),
        .wr_data (upd.entry),
        .rd_en   (s_accept),
        .rd_addr (s_index),
        .rd_data (rd_data)
    );

    assign cur_entry = byp_hit_reg ? byp_data_reg : rd_data;

    csem_exec u_exec (
        .kind          (s1_kind_reg),
        .initial_value (s1_init_reg),
        .is_open       (open_reg[s1_index_reg]),
        .entry         (cur_entry),
        .upd           (upd),
        .res           (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
            byp_hit_reg  <= mem_wr && (s1_index_reg == s_index);
        end else if (fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg  <= kind_t'(s_kind);
            s1_index_reg <= s_index;
            s1_init_reg  <= s_initial_value;
            byp_data_reg <= upd.entry;
        end
    end

    // open flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else if (fire && upd.flag_wr) begin
            open_reg[s1_index_reg] <= upd.flag_val;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_res_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_res_reg.status;
    assign m_count  = m_res_reg.count;
    assign m_wake   = m_res_reg.wake;

endmodule
